// ----- design/line_substring_filter_unit_macros.svh -----
// assertion macros shared by the filter rtl
`ifndef LINE_SUBSTRING_FILTER_UNIT_MACROS_SVH
`define LINE_SUBSTRING_FILTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LSF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define LSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// condition that holds on every cycle
`define LSF_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`else

`define LSF_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define LSF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define LSF_ASSERT_ALWAYS(lbl, clk, rst, cond)

`endif

`endif

// ----- design/lsf_pkg.sv -----
package lsf_pkg;

   // fixed field widths
   localparam int BYTE_W       = 8;
   localparam int LENGTH_W     = 19;
   localparam int QLEN_W       = 5;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 2;
   localparam int QUERY_BYTES  = 16;

   // parameter defaults
   localparam int QUERY_MAX_DEF = 16;
   localparam int MAX_LINE_DEF  = 262144;

   // special stream bytes
   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
   localparam logic [BYTE_W-1:0] NUL_BYTE     = 8'd0;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUERY_LOW    = 2'd0,
      CSR_QUERY_HIGH   = 2'd1,
      CSR_QUERY_LENGTH = 2'd2
   } lsf_csr_index_type;

   // per-byte control handed to the cells and the length counter
   typedef struct packed {
      logic step;
      logic clear;
   } lsf_step_ctrl_type;

endpackage

// ----- design/line_substring_filter_unit.sv -----
// line substring filter
//
// req_ carries one text byte per transfer; byte 10 ends a line. For every
// line ending, one verdict leaves on rsp_: matched, dropped (length reached
// MAX_LINE) and the line length without the newline, saturated at MAX_LINE.
// Other bytes produce no result; a final line without a newline yields none.
// csr_ writes the query: index 0 low query bytes, 1 high bytes, 2 length.
// Matching runs through a row of QUERY_MAX shift-and cells, one query byte
// per cell, each passing its partial match bit to the next cell on every
// stepped byte. Throughput is one byte per cycle unless req_ready is low.
// A newline's verdict shows on rsp_ in the cycle after its transfer. The
// verdict register sits between the channels: req_ready stays high while it
// is empty or being taken, so a stalled receiver stops input only when a
// verdict is waiting and the next byte is accepted in the same cycle the
// verdict is taken. Reset clears the query registers, the cell bits, line
// flags and the length count and empties the verdict register; no clearing
// pass is needed. csr_ready is always high.
module line_substring_filter_unit
   import lsf_pkg::*;
#(
   parameter int QUERY_MAX = QUERY_MAX_DEF,
   parameter int MAX_LINE  = MAX_LINE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [BYTE_W-1:0]      req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_line_matched,
   output logic                   rsp_line_dropped,
   output logic [LENGTH_W-1:0]    rsp_line_length,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

`include "line_substring_filter_unit_macros.svh"

   localparam int CNT_W = $clog2(MAX_LINE + 1);

   // query registers
   logic [CSR_DATA_W-1:0] query_low_ff;
   logic [CSR_DATA_W-1:0] query_high_ff;
   logic [QLEN_W-1:0]     query_length_ff;
   logic [2*CSR_DATA_W-1:0] query_flat;

   // line state
   logic nul_seen_ff;
   logic nul_seen_in;
   logic found_ff;
   logic found_in;

   // verdict register
   logic                rsp_valid_ff;
   logic                rsp_matched_ff;
   logic                rsp_dropped_ff;
   logic [LENGTH_W-1:0] rsp_length_ff;

   logic              req_xfer;
   logic              is_newline;
   logic              is_nul;
   logic              dropped_now;
   logic              any_found_hit;
   lsf_step_ctrl_type cell_ctrl;
   lsf_step_ctrl_type count_ctrl;
   logic [CNT_W-1:0]  line_count;
   logic              line_at_max;

   logic [QUERY_MAX:0]   alive_chain;
   logic [QUERY_MAX:0]   bit_chain;
   logic [QUERY_MAX-1:0] cell_hit;
   logic [QUERY_MAX-1:0] cell_last;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         query_low_ff    <= '0;
         query_high_ff   <= '0;
         query_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (lsf_csr_index_type'(csr_index))
            CSR_QUERY_LOW:    query_low_ff    <= csr_data;
            CSR_QUERY_HIGH:   query_high_ff   <= csr_data;
            CSR_QUERY_LENGTH: query_length_ff <= csr_data[QLEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign query_flat = {query_high_ff, query_low_ff};

   // byte classification and step control
   assign is_newline = (req_data_byte == NEWLINE_BYTE);
   assign is_nul     = (req_data_byte == NUL_BYTE);

   assign count_ctrl.step  = req_xfer && !is_newline;
   assign count_ctrl.clear = req_xfer && is_newline;

   // an empty query leaves the partial match bits untouched
   assign cell_ctrl.step  = req_xfer && !is_newline && !is_nul && !nul_seen_ff
                            && alive_chain[1];
   assign cell_ctrl.clear = count_ctrl.clear;

   // row of shift-and cells
   assign alive_chain[0] = 1'b1;
   assign bit_chain[0]   = 1'b1;

   for (genvar k = 0; k < QUERY_MAX; k++) begin : g_cell
      logic alive_k;
      lsf_match_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .data_byte    (req_data_byte),
         .query_byte   (query_flat[k*BYTE_W +: BYTE_W]),
         .query_length (query_length_ff),
         .alive_in     (alive_chain[k]),
         .bit_in       (bit_chain[k]),
         .alive_out    (alive_k),
         .bit_out      (bit_chain[k+1]),
         .hit          (cell_hit[k])
      );
      assign alive_chain[k+1] = alive_k;
   end

   // last live cell reports a full match
   for (genvar k = 0; k < QUERY_MAX; k++) begin : g_last
      if (k == QUERY_MAX - 1) begin : g_end
         assign cell_last[k] = alive_chain[k+1];
      end else begin : g_mid
         assign cell_last[k] = alive_chain[k+1] && !alive_chain[k+2];
      end
   end

   assign any_found_hit = |(cell_hit & cell_last);

   // line length
   lsf_length_counter #(
      .MAX_LINE (MAX_LINE)
   ) u_length (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (count_ctrl),
      .count  (line_count),
      .at_max (line_at_max)
   );

   // line flags
   always_comb begin
      nul_seen_in = nul_seen_ff;
      found_in    = found_ff;
      if (count_ctrl.clear) begin
         nul_seen_in = 1'b0;
         found_in    = 1'b0;
      end else begin
         if (count_ctrl.step && is_nul) begin
            nul_seen_in = 1'b1;
         end
         if (any_found_hit) begin
            found_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nul_seen_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         nul_seen_ff <= nul_seen_in;
         found_ff    <= found_in;
      end
   end

   // verdict register
   assign dropped_now = line_at_max;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (count_ctrl.clear) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (count_ctrl.clear) begin
         rsp_matched_ff <= !dropped_now && (found_ff || !alive_chain[1]);
         rsp_dropped_ff <= dropped_now;
         rsp_length_ff  <= LENGTH_W'(line_count);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_matched = rsp_matched_ff;
   assign rsp_line_dropped = rsp_dropped_ff;
   assign rsp_line_length  = rsp_length_ff;

   // checks
   `LSF_ASSERT_SAME(a_drop_not_match, clock, reset, rsp_valid_ff && rsp_dropped_ff, !rsp_matched_ff)
   `LSF_ASSERT_NEXT(a_newline_gives_verdict, clock, reset, count_ctrl.clear, rsp_valid_ff)
   `LSF_ASSERT_NEXT(a_newline_clears_line, clock, reset, count_ctrl.clear, line_count == '0 && !found_ff && !nul_seen_ff)
   `LSF_ASSERT_ALWAYS(a_count_saturates, clock, reset, line_count <= CNT_W'(MAX_LINE))
   `LSF_ASSERT_SAME(a_no_step_after_nul, clock, reset, nul_seen_ff, !cell_ctrl.step)

endmodule

// ----- design/lsf_match_cell.sv -----
module lsf_match_cell
   import lsf_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  lsf_step_ctrl_type   ctrl,
   input  logic [BYTE_W-1:0]   data_byte,
   input  logic [BYTE_W-1:0]   query_byte,
   input  logic [QLEN_W-1:0]   query_length,
   input  logic                alive_in,
   input  logic                bit_in,
   output logic                alive_out,
   output logic                bit_out,
   output logic                hit
);

   logic bit_ff;
   logic bit_in_next;
   logic byte_eq;

   // this cell is inside the effective query: below length, no nul so far
   assign alive_out = alive_in && (QLEN_W'(CELL_INDEX) < query_length)
                      && (query_byte != NUL_BYTE);

   assign byte_eq     = (query_byte == data_byte);
   assign bit_in_next = bit_in && byte_eq && alive_out;
   assign hit         = ctrl.step && bit_in_next;

   // partial match bit, shifted in from the left neighbor
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         bit_ff <= 1'b0;
      end else if (ctrl.step) begin
         bit_ff <= bit_in_next;
      end
   end

   assign bit_out = bit_ff;

endmodule

// ----- design/lsf_length_counter.sv -----
module lsf_length_counter
   import lsf_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEF,
   localparam int CNT_W   = $clog2(MAX_LINE + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  lsf_step_ctrl_type ctrl,
   output logic [CNT_W-1:0]  count,
   output logic              at_max
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign at_max = (count_ff >= CNT_W'(MAX_LINE));

   // saturating line length
   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.step && !at_max) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

// ----- tb/line_substring_filter_checker.sv -----
module line_substring_filter_checker
   import lsf_pkg::*;
#(
   parameter int QUERY_MAX = QUERY_MAX_DEF,
   parameter int MAX_LINE  = MAX_LINE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   rsp_line_matched,
   input  logic                   rsp_line_dropped,
   input  logic [LENGTH_W-1:0]    rsp_line_length,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                matched;
      logic                dropped;
      logic [LENGTH_W-1:0] length;
   } line_verdict_type;

   // query registers as the block should hold them
   logic [CSR_DATA_W-1:0] query_low;
   logic [CSR_DATA_W-1:0] query_high;
   logic [QLEN_W-1:0]     query_len;

   // per-line scan state
   logic [QUERY_BYTES-1:0] match_bits;
   logic                   query_found;
   logic                   nul_seen;
   int unsigned            line_count;

   line_verdict_type expected_verdicts [$];
   int               mismatches = 0;

   function automatic logic [BYTE_W-1:0] query_char(input int k);
      logic [2*CSR_DATA_W-1:0] whole;
      whole = {query_high, query_low};
      return whole[BYTE_W*k +: BYTE_W];
   endfunction

   // length clipped to the cell count and cut at the first nul
   function automatic int active_query_length();
      int n;
      int k;
      n = int'(query_len);
      if (n > QUERY_MAX) n = QUERY_MAX;
      if (n > QUERY_BYTES) n = QUERY_BYTES;
      for (k = 0; k < n; k++) begin
         if (query_char(k) == NUL_BYTE) return k;
      end
      return n;
   endfunction

   function automatic void clear_line();
      match_bits  = '0;
      query_found = 1'b0;
      nul_seen    = 1'b0;
      line_count  = 0;
   endfunction

   // advance the line state by one byte, queue a verdict on newline
   task automatic scan_byte(input logic [BYTE_W-1:0] value);
      int                     span;
      int                     k;
      logic [QUERY_BYTES-1:0] hit;
      line_verdict_type       verdict;
      span = active_query_length();
      if (value == NEWLINE_BYTE) begin
         verdict.dropped = (line_count >= MAX_LINE);
         verdict.matched = !verdict.dropped && (query_found || span == 0);
         verdict.length  = line_count[LENGTH_W-1:0];
         expected_verdicts.push_back(verdict);
         clear_line();
      end else begin
         if (line_count < MAX_LINE) line_count = line_count + 1;
         if (value == NUL_BYTE) begin
            nul_seen = 1'b1;
         end else if (!nul_seen && span > 0) begin
            hit = '0;
            for (k = 0; k < span; k++) hit[k] = (query_char(k) == value);
            match_bits = ((match_bits << 1) | 16'd1) & hit;
            if (match_bits[span-1]) query_found = 1'b1;
         end
      end
   endtask

   task automatic note_mismatch(input string field, input logic [LENGTH_W-1:0] want,
                                input logic [LENGTH_W-1:0] seen);
      $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, seen);
      mismatches++;
   endtask

   // watch all three channels at each edge
   always @(posedge clock) begin : watch
      line_verdict_type want;
      if (reset) begin
         query_low  = '0;
         query_high = '0;
         query_len  = '0;
         clear_line();
         expected_verdicts.delete();
         pending_count <= 0;
         fail_count    <= mismatches;
      end else begin
         // register write
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_QUERY_LOW:    query_low  = csr_data;
               CSR_QUERY_HIGH:   query_high = csr_data;
               CSR_QUERY_LENGTH: query_len  = csr_data[QLEN_W-1:0];
               default: ;
            endcase
         end
         // verdict transfer, always older than a byte taken at this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t ns: verdict with none expected, actual %0d/%0d/%0d",
                        $time, rsp_line_matched, rsp_line_dropped, rsp_line_length);
               mismatches++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_line_matched !== want.matched)
                  note_mismatch("line_matched", LENGTH_W'(want.matched),
                                LENGTH_W'(rsp_line_matched));
               if (rsp_line_dropped !== want.dropped)
                  note_mismatch("line_dropped", LENGTH_W'(want.dropped),
                                LENGTH_W'(rsp_line_dropped));
               if (rsp_line_length !== want.length)
                  note_mismatch("line_length", want.length, rsp_line_length);
            end
         end
         // byte transfer
         if (req_valid && req_ready) scan_byte(req_data_byte);
         pending_count <= expected_verdicts.size();
         fail_count    <= mismatches;
      end
   end

endmodule

// ----- tb/line_substring_filter_unit_test.sv -----
module line_substring_filter_unit_test
   import lsf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 9;
   localparam int QUERY_LIMIT   = QUERY_MAX_DEF;
   localparam int LINE_LIMIT    = MAX_LINE_DEF;
   localparam int RANDOM_ITEMS  = 1700;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 3;
   localparam int STALL_LIMIT   = 5000;

   // index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   // stands in for newline inside lines that must stay whole
   localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h0B;
   localparam logic [BYTE_W-1:0] ALPHA_BASE = 8'h61;

   typedef enum int {RECV_OPEN, RECV_COIN, RECV_SPARSE, RECV_CADENCE} recv_mode_type;
   typedef enum int {
      QUERY_EMPTY, QUERY_ALL_ONES, QUERY_OVERSIZED, QUERY_WITH_NUL, QUERY_PLAIN
   } query_flavor_type;

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_ready;
   logic [BYTE_W-1:0]      req_data_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready     = 1'b0;
   logic                   rsp_line_matched;
   logic                   rsp_line_dropped;
   logic [LENGTH_W-1:0]    rsp_line_length;
   logic                   csr_valid     = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index     = '0;
   logic [CSR_DATA_W-1:0]  csr_data      = '0;

   int fail_count;
   int pending_count;

   // sender pacing and the query the line generator aims at
   int          burst_left = 0;
   int          bytes_sent = 0;
   logic [BYTE_W-1:0] query_text [QUERY_BYTES];
   int          query_span = 0;

   // receiver state
   int            hold_requests = 0;
   int            holds_served  = 0;
   int            hold_left     = 0;
   int            mode_left     = 0;
   int            cadence_tick  = 0;
   recv_mode_type recv_mode     = RECV_OPEN;
   int            stall_cycles  = 0;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   line_substring_filter_unit #(
      .QUERY_MAX(QUERY_LIMIT),
      .MAX_LINE (LINE_LIMIT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_matched (rsp_line_matched),
      .rsp_line_dropped (rsp_line_dropped),
      .rsp_line_length  (rsp_line_length),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   line_substring_filter_checker #(
      .QUERY_MAX(QUERY_LIMIT),
      .MAX_LINE (LINE_LIMIT)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_matched (rsp_line_matched),
      .rsp_line_dropped (rsp_line_dropped),
      .rsp_line_length  (rsp_line_length),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // receiver: long hold on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            recv_mode <= recv_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(20, 120);
         end else begin
            mode_left <= mode_left - 1;
         end
         cadence_tick <= cadence_tick + 1;
         case (recv_mode)
            RECV_OPEN:    rsp_ready <= 1'b1;
            RECV_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
            RECV_SPARSE:  rsp_ready <= ($urandom_range(0, 3) == 0);
            RECV_CADENCE: rsp_ready <= (cadence_tick % 3 != 0);
            default:      rsp_ready <= 1'b1;
         endcase
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // one byte transfer; paced bytes come in bursts with gaps between
   task automatic send_byte(input logic [BYTE_W-1:0] value, input bit paced);
      int gap;
      if (paced) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
         end
         burst_left--;
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_string(input string text);
      int k;
      for (k = 0; k < text.len(); k++) send_byte(text[k], 1'b1);
   endtask

   // stop sending, wait out all verdicts and the pipeline behind them
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // write all query registers while the block is idle
   task automatic load_query(input logic [CSR_DATA_W-1:0] low,
                             input logic [CSR_DATA_W-1:0] high,
                             input logic [QLEN_W-1:0] len);
      int k;
      settle();
      if ($urandom_range(0, 3) == 0) write_reg(CSR_SPARE_INDEX, {$urandom, $urandom});
      write_reg(CSR_QUERY_LOW, low);
      write_reg(CSR_QUERY_HIGH, high);
      write_reg(CSR_QUERY_LENGTH, len);
      csr_valid <= 1'b0;
      for (k = 0; k < QUERY_BYTES; k++)
         query_text[k] = (k < 8) ? low[BYTE_W*k +: BYTE_W] : high[BYTE_W*(k-8) +: BYTE_W];
      query_span = (len > QUERY_BYTES) ? QUERY_BYTES : int'(len);
   endtask

   task automatic pick_query();
      logic [2*CSR_DATA_W-1:0] whole;
      logic [QLEN_W-1:0]       len;
      query_flavor_type        flavor;
      int                      roll;
      int                      k;
      roll   = $urandom_range(0, 9);
      flavor = (roll < QUERY_PLAIN) ? query_flavor_type'(roll) : QUERY_PLAIN;
      // mostly a small alphabet so that partial matches restart often
      for (k = 0; k < QUERY_BYTES; k++)
         whole[BYTE_W*k +: BYTE_W] = $urandom_range(0, 1)
                                     ? BYTE_W'(ALPHA_BASE + $urandom_range(0, 3))
                                     : BYTE_W'($urandom_range(1, 255));
      len = QLEN_W'($urandom_range(1, QUERY_BYTES));
      case (flavor)
         QUERY_EMPTY: begin
            whole = '0;
            len   = '0;
         end
         QUERY_ALL_ONES: begin
            whole = '1;
            len   = QLEN_W'(QUERY_BYTES);
         end
         QUERY_OVERSIZED: len = QLEN_W'($urandom_range(QUERY_BYTES + 1, 31));
         QUERY_WITH_NUL:  whole[BYTE_W*$urandom_range(0, QUERY_BYTES-1) +: BYTE_W] = NUL_BYTE;
         default: ;
      endcase
      load_query(whole[CSR_DATA_W-1:0], whole[2*CSR_DATA_W-1:CSR_DATA_W], len);
   endtask

   function automatic logic [BYTE_W-1:0] filler_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50 && query_span > 0) return query_text[$urandom_range(0, query_span - 1)];
      if (roll < 80) return BYTE_W'(ALPHA_BASE + $urandom_range(0, 3));
      if (roll < 96) return BYTE_W'($urandom_range(0, 255));
      return NUL_BYTE;
   endfunction

   // whole lines carry no early newline
   function automatic logic [BYTE_W-1:0] line_byte(input logic [BYTE_W-1:0] value,
                                                    input bit solid);
      return (solid && value == NEWLINE_BYTE) ? FILL_BYTE : value;
   endfunction

   // count bytes of text, the query planted somewhere in most lines
   task automatic send_text(input int count, input bit solid, input bit close);
      int k;
      int j;
      int insert_at;
      insert_at = (query_span > 0 && count > 0 && $urandom_range(0, 2) != 0)
                  ? $urandom_range(0, count - 1) : -1;
      k = 0;
      while (k < count) begin
         if (k == insert_at) begin
            for (j = 0; j < query_span && k < count; j++) begin
               send_byte(line_byte(query_text[j], solid), !solid);
               k++;
            end
         end else begin
            send_byte(line_byte(filler_byte(), solid), !solid);
            k++;
         end
      end
      if (close) send_byte(NEWLINE_BYTE, !solid);
   endtask

   initial begin
      int phase_index;
      int line_total;
      int line_index;
      int k;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty query out of reset: every kept line matches, the empty one too
      send_byte(NEWLINE_BYTE, 1'b1);
      send_string("zq\n");
      // two-byte query: plain hit, hit after a false start, and a miss
      load_query(64'h6261, '0, 5'd2);
      send_string("xab\n");
      send_string("aab\n");
      send_string("ba\n");
      // nul ahead of the query hides it but still counts toward the length
      send_byte(NUL_BYTE, 1'b1);
      send_string("ab\n");
      // nul inside the query cuts it short
      load_query(64'h64_00_63, '0, 5'd3);
      send_string("c\n");
      // oversized length with extreme bytes uses all sixteen cells
      load_query('1, {8{8'h01}}, 5'd31);
      for (k = 0; k < 8; k++) send_byte(8'hFF, 1'b1);
      for (k = 0; k < 8; k++) send_byte(8'h01, 1'b1);
      send_byte(NEWLINE_BYTE, 1'b1);
      // query changed mid-line keeps the partial match bits
      load_query(64'h6261, '0, 5'd2);
      send_string("a");
      load_query(64'h627A, '0, 5'd2);
      send_string("b\n");
      // partial match bits survive bytes seen while the query is empty
      load_query(64'h6261, '0, 5'd2);
      send_string("a");
      load_query(64'h6261, '0, 5'd0);
      send_string("x");
      load_query(64'h6261, '0, 5'd2);
      send_string("b\n");
      // query emptied mid-line is judged at the newline
      send_string("q");
      load_query('0, '0, 5'd0);
      send_byte(NEWLINE_BYTE, 1'b1);

      // random phases, each with a fresh query and a drained block
      phase_index = 0;
      while (bytes_sent < RANDOM_ITEMS) begin
         pick_query();
         line_total = $urandom_range(3, 10);
         for (line_index = 0; line_index < line_total; line_index++) begin
            // receiver holds off while lines keep coming
            if (line_index == 1 && phase_index % 6 == 3) hold_requests <= hold_requests + 1;
            if ($urandom_range(0, 15) == 0) begin
               send_text($urandom_range(0, 10), 1'b0, 1'b0);
               pick_query();
               send_text($urandom_range(0, 10), 1'b0, 1'b1);
            end else begin
               send_text($urandom_range(0, 28), 1'b0, 1'b1);
            end
         end
         phase_index++;
      end

      settle();
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
